// File: rtl/core/rtc_pkg.sv
// Package for the rectangular to cylindrical converter: field widths,
// transfer structs, CORDIC constants and the arctangent table.
// No dependencies.
package rtc_pkg;

   localparam int CoordWidth = 16;
   localparam int GuardBits  = 16;
   localparam int AccWidth   = 32;
   // Guard bits plus growth headroom (sqrt(2) * CORDIC gain) plus sign.
   localparam int CordWidth  = CoordWidth + GuardBits + 3;

   // CORDIC gain compensation, Q0.32.
   localparam logic [31:0] GainQ32 = 32'd2608131496;

   // Angle units: 2^31 stands for pi.
   localparam logic [AccWidth-1:0] HalfPi    = 32'h4000_0000;
   localparam logic [AccWidth-1:0] NegHalfPi = 32'hC000_0000;

   typedef struct packed {
      logic signed [CoordWidth-1:0] x_coord;
      logic signed [CoordWidth-1:0] y_coord;
      logic signed [CoordWidth-1:0] z_coord;
   } req_type;

   typedef struct packed {
      logic [CoordWidth-1:0]        radius;
      logic signed [CoordWidth-1:0] angle;
      logic signed [CoordWidth-1:0] height;
   } rsp_type;

   // One pipeline slot of the vectoring engine.
   typedef struct packed {
      logic                         valid;
      logic                         origin;
      logic signed [CordWidth-1:0]  cx;
      logic signed [CordWidth-1:0]  cy;
      logic [AccWidth-1:0]          acc;
      logic signed [CoordWidth-1:0] height;
   } vec_type;

   // round(atan(2^-i) * 2^31 / pi)
   function automatic logic [AccWidth-1:0] atan_units(input logic [4:0] idx);
      logic [AccWidth-1:0] val;
      unique case (idx)
         5'd0:  val = 32'd536870912;
         5'd1:  val = 32'd316933406;
         5'd2:  val = 32'd167458907;
         5'd3:  val = 32'd85004756;
         5'd4:  val = 32'd42667331;
         5'd5:  val = 32'd21354465;
         5'd6:  val = 32'd10680862;
         5'd7:  val = 32'd5340245;
         5'd8:  val = 32'd2670163;
         5'd9:  val = 32'd1335087;
         5'd10: val = 32'd667544;
         5'd11: val = 32'd333772;
         5'd12: val = 32'd166886;
         5'd13: val = 32'd83443;
         5'd14: val = 32'd41722;
         5'd15: val = 32'd20861;
         5'd16: val = 32'd10430;
         5'd17: val = 32'd5215;
         5'd18: val = 32'd2608;
         5'd19: val = 32'd1304;
         5'd20: val = 32'd652;
         5'd21: val = 32'd326;
         5'd22: val = 32'd163;
         5'd23: val = 32'd81;
         5'd24: val = 32'd41;
         5'd25: val = 32'd20;
         5'd26: val = 32'd10;
         5'd27: val = 32'd5;
         5'd28: val = 32'd3;
         5'd29: val = 32'd1;
         5'd30: val = 32'd1;
         5'd31: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

// File: rtl/core/rtc_quadrant.sv
// Input register with quadrant pre-rotation into the right half plane.
// Depends on rtc_pkg.
module rtc_quadrant (
   input  logic             clock,
   input  logic             reset,
   input  logic             valid_in,
   input  rtc_pkg::req_type req_in,
   output rtc_pkg::vec_type vec_out
);
   import rtc_pkg::*;

   localparam int ExtBits = CordWidth - CoordWidth - GuardBits;

   logic signed [CordWidth-1:0] cx0;
   logic signed [CordWidth-1:0] cy0;
   vec_type                     vec_in;
   vec_type                     vec_ff;

   assign cx0 = {{ExtBits{req_in.x_coord[CoordWidth-1]}}, req_in.x_coord,
                 {GuardBits{1'b0}}};
   assign cy0 = {{ExtBits{req_in.y_coord[CoordWidth-1]}}, req_in.y_coord,
                 {GuardBits{1'b0}}};

   always_comb begin
      vec_in.valid  = valid_in;
      vec_in.origin = (req_in.x_coord == '0) && (req_in.y_coord == '0);
      vec_in.height = req_in.z_coord;
      vec_in.cx     = cx0;
      vec_in.cy     = cy0;
      vec_in.acc    = '0;
      if (cx0[CordWidth-1]) begin
         // rotate by -pi/2 or +pi/2 toward the positive x axis
         if (!cy0[CordWidth-1]) begin
            vec_in.cx  = cy0;
            vec_in.cy  = -cx0;
            vec_in.acc = HalfPi;
         end else begin
            vec_in.cx  = -cy0;
            vec_in.cy  = cx0;
            vec_in.acc = NegHalfPi;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vec_ff <= '0;
      end else begin
         vec_ff <= vec_in;
      end
   end

   assign vec_out = vec_ff;

endmodule

// File: rtl/core/rtc_cordic_stage.sv
// One registered CORDIC micro-rotation in vectoring mode.
// Depends on rtc_pkg.
module rtc_cordic_stage #(
   parameter int STAGE = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  rtc_pkg::vec_type vec_in,
   output rtc_pkg::vec_type vec_out
);
   import rtc_pkg::*;

   localparam logic [4:0]          Idx   = 5'(STAGE);
   localparam logic [AccWidth-1:0] Angle = atan_units(Idx);

   logic signed [CordWidth-1:0] dx;
   logic signed [CordWidth-1:0] dy;
   vec_type                     vec_nx;
   vec_type                     vec_ff;

   // arithmetic shifts round toward minus infinity
   assign dx = $signed(vec_in.cy) >>> STAGE;
   assign dy = $signed(vec_in.cx) >>> STAGE;

   always_comb begin
      vec_nx = vec_in;
      if (!vec_in.cy[CordWidth-1]) begin
         vec_nx.cx  = vec_in.cx + dx;
         vec_nx.cy  = vec_in.cy - dy;
         vec_nx.acc = vec_in.acc + Angle;
      end else begin
         vec_nx.cx  = vec_in.cx - dx;
         vec_nx.cy  = vec_in.cy + dy;
         vec_nx.acc = vec_in.acc - Angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vec_ff <= '0;
      end else begin
         vec_ff <= vec_nx;
      end
   end

   assign vec_out = vec_ff;

endmodule

// File: rtl/core/rtc_finish.sv
// Gain compensation, radius rounding and saturation, angle rounding:
// three register stages after the CORDIC chain. Depends on rtc_pkg.
module rtc_finish (
   input  logic             clock,
   input  logic             reset,
   input  rtc_pkg::vec_type vec_in,
   output logic             rsp_valid,
   output rtc_pkg::rsp_type rsp_out
);
   import rtc_pkg::*;

   localparam int MagWidth  = CordWidth - 1;
   localparam int LowWidth  = MagWidth / 2;
   localparam int HighWidth = MagWidth - LowWidth;
   localparam int SumWidth  = MagWidth + 33;
   localparam int RadShift  = GuardBits + 32;
   localparam int RadWidth  = SumWidth - RadShift;
   localparam int AngShift  = AccWidth - CoordWidth;

   localparam logic [SumWidth-1:0]   RoundHalf = SumWidth'(1) << (RadShift - 1);
   localparam logic [RadWidth-1:0]   MaxRad    = RadWidth'({CoordWidth{1'b1}});

   // stage 1: partial products, angle rounding
   logic [MagWidth-1:0]          mag;
   logic [LowWidth+31:0]         plo_in;
   logic [HighWidth+31:0]        phi_in;
   logic [CoordWidth-1:0]        ang_round;
   logic [CoordWidth-1:0]        angle_in;
   logic                         s1_valid_ff;
   logic [LowWidth+31:0]         s1_plo_ff;
   logic [HighWidth+31:0]        s1_phi_ff;
   logic [CoordWidth-1:0]        s1_angle_ff;
   logic signed [CoordWidth-1:0] s1_height_ff;

   // stage 2: product sum with rounding offset
   logic [SumWidth-1:0]          sum_in;
   logic                         s2_valid_ff;
   logic [SumWidth-1:0]          s2_sum_ff;
   logic [CoordWidth-1:0]        s2_angle_ff;
   logic signed [CoordWidth-1:0] s2_height_ff;

   // stage 3: saturate into the result register
   logic [RadWidth-1:0]          rad_full;
   rsp_type                      rsp_in;
   logic                         rsp_valid_ff;
   rsp_type                      rsp_ff;

   assign mag    = vec_in.cx[CordWidth-1] ? '0 : vec_in.cx[MagWidth-1:0];
   assign plo_in = {{32{1'b0}}, mag[LowWidth-1:0]} * {{LowWidth{1'b0}}, GainQ32};
   assign phi_in = {{32{1'b0}}, mag[MagWidth-1:LowWidth]} *
                   {{HighWidth{1'b0}}, GainQ32};

   generate
      if (AngShift > 0) begin : g_ang_round
         logic [AccWidth-1:0] ang_sum;
         assign ang_sum   = vec_in.acc + (AccWidth'(1) << (AngShift - 1));
         assign ang_round = ang_sum[AccWidth-1:AngShift];
      end else begin : g_ang_full
         assign ang_round = vec_in.acc[CoordWidth-1:0];
      end
   endgenerate

   assign angle_in = vec_in.origin ? '0 : ang_round;

   always_ff @(posedge clock) begin
      s1_plo_ff    <= plo_in;
      s1_phi_ff    <= phi_in;
      s1_angle_ff  <= angle_in;
      s1_height_ff <= vec_in.height;
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= vec_in.valid;
      end
   end

   assign sum_in = SumWidth'({s1_phi_ff, {LowWidth{1'b0}}}) + SumWidth'(s1_plo_ff)
                   + RoundHalf;

   always_ff @(posedge clock) begin
      s2_sum_ff    <= sum_in;
      s2_angle_ff  <= s1_angle_ff;
      s2_height_ff <= s1_height_ff;
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   assign rad_full = s2_sum_ff[SumWidth-1:RadShift];

   always_comb begin
      rsp_in.radius = (rad_full > MaxRad) ? {CoordWidth{1'b1}}
                                          : rad_full[CoordWidth-1:0];
      rsp_in.angle  = s2_angle_ff;
      rsp_in.height = s2_height_ff;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out   = rsp_ff;

endmodule

// File: rtl/core/rectangular_to_cylindrical.sv
// Rectangular to cylindrical converter, top level.
// Depends on rtc_pkg, rtc_quadrant, rtc_cordic_stage and rtc_finish.
//
// Usage:
//   Drive req_data (x_coord, y_coord, z_coord) and raise start. A point
//   transfers at each rising edge with start high and busy low. busy is
//   high only while reset is asserted, so a new point may enter every
//   cycle: one point per clock sustained.
//   Each result shows on rsp_data for exactly one cycle with rsp_strobe
//   high, after its point has passed one input register with quadrant
//   pre-rotation, one register per CORDIC micro-rotation, then the gain
//   multiply, product sum and saturation stages.
//   Results come out in input order. The receiver cannot stall, so the
//   pipeline never holds; every stage advances on every clock.
//   radius is sqrt(x^2+y^2) at the input scale, saturated to the field;
//   angle is atan2(y,x) with 2^15 standing for pi (+pi wraps to -pi);
//   height is z copied. The origin yields radius 0 and angle 0.
//   Synchronous reset drops every point in flight; no result appears for
//   any point transferred before reset.
module rectangular_to_cylindrical #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rtc_pkg::req_type req_data,
   output logic             rsp_strobe,
   output rtc_pkg::rsp_type rsp_data
);
   import rtc_pkg::*;

   localparam int Latency = CORDIC_STEPS + 4;

   logic    req_accept;
   vec_type chain [CORDIC_STEPS+1];

   // hold off transfers only while in reset
   assign busy       = reset;
   assign req_accept = start && !busy;

   rtc_quadrant u_quadrant (
      .clock    (clock),
      .reset    (reset),
      .valid_in (req_accept),
      .req_in   (req_data),
      .vec_out  (chain[0])
   );

   // one micro-rotation per register stage
   generate
      for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
         rtc_cordic_stage #(
            .STAGE (g)
         ) u_stage (
            .clock   (clock),
            .reset   (reset),
            .vec_in  (chain[g]),
            .vec_out (chain[g+1])
         );
      end
   endgenerate

   rtc_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .vec_in    (chain[CORDIC_STEPS]),
      .rsp_valid (rsp_strobe),
      .rsp_out   (rsp_data)
   );

`ifndef SYNTHESIS
   // every strobe traces back to a matching earlier input transfer
   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, Latency))
      else $error("result strobe without matching input transfer");

   // height travels alongside the CORDIC data without skew
   a_height_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.height == $past(req_data.z_coord, Latency))
      else $error("height out of step with its point");

   // origin gives zero radius and zero angle
   a_origin_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(start && !busy && req_data.x_coord == '0
                          && req_data.y_coord == '0, Latency)
      |-> rsp_data.radius == '0 && rsp_data.angle == '0)
      else $error("origin did not give zero radius and angle");
`endif

endmodule
